// ===== rtl/eikonal_upwind_cost_update_unit_macros.svh =====
// Assertion macros shared by the cost update unit RTL.
`ifndef EIKONAL_UPWIND_COST_UPDATE_UNIT_MACROS_SVH
`define EIKONAL_UPWIND_COST_UPDATE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define EUC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("cost update unit assertion failed");
`define EUC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("cost update unit assertion failed");
`else
`define EUC_ASSERT(lbl, clk, rst_n, prop)
`define EUC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/euc_pkg.sv =====
// Shared constants, types and helpers of the eikonal cost update unit.
package euc_pkg;
	localparam int COST_W     = 32;
	localparam int RISK_W     = 8;
	localparam int RISKF_W    = RISK_W + 1;
	localparam int RW_W       = RISK_W + 5;
	localparam int PROD_W     = COST_W + RW_W;
	localparam int CW_W       = PROD_W - RISK_W;
	localparam int SUM_W      = COST_W + 1;
	localparam int ROOT_W     = COST_W + 1;
	localparam int RAD_W      = 2 * COST_W + 1;
	localparam int TRIAL_W    = RAD_W + 2;
	localparam int TC_W       = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int MODES_W    = 6;
	localparam int MQ_DEPTH   = 4;
	localparam int MQ_PTR_W   = 2;
	localparam int MQ_CNT_W   = 3;

	localparam logic [COST_W-1:0] COST_INF  = '1;
	localparam logic [COST_W-1:0] COST_MAXF = {{(COST_W-1){1'b1}}, 1'b0};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COST_SCALE = 3'd0,
		CFG_TERRAIN_0  = 3'd1,
		CFG_TERRAIN_1  = 3'd2,
		CFG_TERRAIN_2  = 3'd3,
		CFG_LOCAL_MODE = 3'd4,
		CFG_LOCO_MODES = 3'd5
	} cfg_idx_t;

	// Item handed from front to back through the mid queue
	typedef struct packed {
		logic [COST_W-1:0] tx;
		logic [COST_W-1:0] ty;
		logic [COST_W-1:0] c;
		logic [COST_W-1:0] d;
		logic              use_eik;
		logic [COST_W-1:0] cur;
		logic [1:0]        mode;
	} mq_item_t;

	// Payload carried alongside the square root pipeline
	typedef struct packed {
		logic [SUM_W-1:0]  sum;
		logic [COST_W-1:0] fb;
		logic              use_eik;
		logic [COST_W-1:0] cur;
		logic [1:0]        mode;
	} back_pay_t;

	typedef struct packed {
		logic [COST_W-1:0] new_cost;
		logic              improved;
		logic              joins_band;
		logic [1:0]        locomotion_mode;
		logic              still_infinite;
	} result_t;

	function automatic logic [COST_W-1:0] axis_min(input logic [COST_W-1:0] c0,
			input logic p0, input logic [COST_W-1:0] c1, input logic p1);
		logic [COST_W-1:0] r;
		if (p0 && p1) begin
			r = (c0 < c1) ? c0 : c1;
		end else if (p0) begin
			r = c0;
		end else if (p1) begin
			r = c1;
		end else begin
			r = COST_INF;
		end
		return r;
	endfunction
endpackage

// ===== rtl/euc_front.sv =====
// Front end: configuration registers, axis minima and cell cost.
module euc_front
	import euc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	output logic                  full,
	input  logic [COST_W-1:0]     x_low_cost,
	input  logic                  x_low_present,
	input  logic [COST_W-1:0]     x_high_cost,
	input  logic                  x_high_present,
	input  logic [COST_W-1:0]     y_low_cost,
	input  logic                  y_low_present,
	input  logic [COST_W-1:0]     y_high_cost,
	input  logic                  y_high_present,
	input  logic [1:0]            terrain_class,
	input  logic [RISKF_W-1:0]    obstacle_risk,
	input  logic [COST_W-1:0]     current_cost,
	input  logic                  mq_full,
	output logic                  mq_wr,
	output mq_item_t              mq_data
);
	logic [TC_W-1:0]    cost_scale_q, tc0_q, tc1_q, tc2_q;
	logic               local_mode_q;
	logic [MODES_W-1:0] modes_q;

	logic               front_en;
	logic [1:0]         cls_n;
	logic [TC_W-1:0]    tc_n;
	logic [1:0]         mode_n;
	logic [COST_W-1:0]  g_n;

	logic               v_s1, v_s2;
	logic [COST_W-1:0]  tx_s1, ty_s1, g_s1, cur_s1;
	logic [RISKF_W-1:0] risk_s1;
	logic [1:0]         mode_s1;
	logic               lm_s1;
	logic [COST_W-1:0]  tx_s2, ty_s2, cur_s2;
	logic [CW_W-1:0]    cw_s2;
	logic [1:0]         mode_s2;

	logic [RW_W-1:0]    rw_n;
	logic [PROD_W-1:0]  prod_n;
	logic [CW_W-1:0]    cw_n;
	logic [COST_W-1:0]  c_n, d_n;
	logic               fin_n;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_scale_q <= TC_W'(256);
			tc0_q        <= TC_W'(256);
			tc1_q        <= TC_W'(256);
			tc2_q        <= TC_W'(256);
			local_mode_q <= 1'b0;
			modes_q      <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_COST_SCALE: cost_scale_q <= cfg_data;
				CFG_TERRAIN_0:  tc0_q        <= cfg_data;
				CFG_TERRAIN_1:  tc1_q        <= cfg_data;
				CFG_TERRAIN_2:  tc2_q        <= cfg_data;
				CFG_LOCAL_MODE: local_mode_q <= cfg_data[0];
				CFG_LOCO_MODES: modes_q      <= cfg_data[MODES_W-1:0];
				default: ;
			endcase
		end
	end

	// Stall the whole front when the last stage cannot drain
	assign front_en = !(v_s2 && mq_full);
	assign full     = !front_en;

	// Classify terrain: class three folds onto class zero
	always_comb begin
		cls_n = (terrain_class == 2'd3) ? 2'd0 : terrain_class;
		case (cls_n)
			2'd1: begin
				tc_n   = tc1_q;
				mode_n = modes_q[3:2];
			end
			2'd2: begin
				tc_n   = local_mode_q ? tc1_q : tc2_q;
				mode_n = modes_q[5:4];
			end
			default: begin
				tc_n   = tc0_q;
				mode_n = modes_q[1:0];
			end
		endcase
	end

	assign g_n = COST_W'({{TC_W{1'b0}}, cost_scale_q} * {{TC_W{1'b0}}, tc_n});

	// Stage 1: axis minima and base cell cost
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (front_en) begin
			v_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (front_en) begin
			tx_s1   <= axis_min(x_low_cost, x_low_present, x_high_cost, x_high_present);
			ty_s1   <= axis_min(y_low_cost, y_low_present, y_high_cost, y_high_present);
			g_s1    <= g_n;
			risk_s1 <= obstacle_risk;
			cur_s1  <= current_cost;
			mode_s1 <= mode_n;
			lm_s1   <= local_mode_q;
		end
	end

	// Risk weighting for local mode
	assign rw_n   = (RW_W'(1) << RISK_W) + RW_W'(risk_s1) * RW_W'(9);
	assign prod_n = PROD_W'(g_s1) * PROD_W'(rw_n);
	assign cw_n   = lm_s1 ? prod_n[PROD_W-1:RISK_W] : CW_W'(g_s1);

	// Stage 2: weighted cell cost
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (front_en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (front_en) begin
			tx_s2   <= tx_s1;
			ty_s2   <= ty_s1;
			cw_s2   <= cw_n;
			cur_s2  <= cur_s1;
			mode_s2 <= mode_s1;
		end
	end

	// Saturate cost, form axis gap and pick the update form
	assign c_n   = (cw_s2 > CW_W'(COST_MAXF)) ? COST_MAXF : cw_s2[COST_W-1:0];
	assign d_n   = (tx_s2 > ty_s2) ? (tx_s2 - ty_s2) : (ty_s2 - tx_s2);
	assign fin_n = (tx_s2 != COST_INF) && (ty_s2 != COST_INF);

	assign mq_wr = v_s2 && front_en;
	always_comb begin
		mq_data.tx      = tx_s2;
		mq_data.ty      = ty_s2;
		mq_data.c       = c_n;
		mq_data.d       = d_n;
		mq_data.use_eik = fin_n && (d_n < c_n);
		mq_data.cur     = cur_s2;
		mq_data.mode    = mode_s2;
	end
endmodule

// ===== rtl/euc_mid_queue.sv =====
// Short queue that decouples the front end from the back end.
`include "eikonal_upwind_cost_update_unit_macros.svh"
module euc_mid_queue
	import euc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr,
	input  mq_item_t wdata,
	input  logic     rd,
	output mq_item_t rdata,
	output logic     full,
	output logic     empty
);
	mq_item_t            mem_q [MQ_DEPTH];
	logic [MQ_PTR_W-1:0] wptr_q, rptr_q;
	logic [MQ_CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == MQ_CNT_W'(MQ_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	`EUC_ASSERT(a_mq_no_overflow, clk, arst_n, wr |-> !full)
	`EUC_ASSERT(a_mq_no_underflow, clk, arst_n, rd |-> !empty)
	`EUC_ASSERT_NEVER(a_mq_cnt_range, clk, arst_n, cnt_q > MQ_CNT_W'(MQ_DEPTH))
endmodule

// ===== rtl/euc_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage.
module euc_sqrt_pipe
	import euc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [RAD_W-1:0]  in_rad,
	input  back_pay_t         in_pay,
	output logic              out_valid,
	output logic [ROOT_W-1:0] out_root,
	output back_pay_t         out_pay
);
	logic [RAD_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	back_pay_t         pay_s  [ROOT_W];
	logic              v_s    [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam int BIT = ROOT_W - 1 - k;
		logic [RAD_W-1:0]   rem_p, rem_n;
		logic [ROOT_W-1:0]  root_p, root_n;
		back_pay_t          pay_p;
		logic               v_p;
		logic [TRIAL_W-1:0] trial;
		logic               ge;

		if (k == 0) begin : g_first
			assign rem_p  = in_rad;
			assign root_p = '0;
			assign pay_p  = in_pay;
			assign v_p    = in_valid;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign pay_p  = pay_s[k-1];
			assign v_p    = v_s[k-1];
		end

		// Try setting this root bit against the remaining radicand
		assign trial  = (TRIAL_W'(root_p) << (BIT + 1)) + (TRIAL_W'(1) << (2 * BIT));
		assign ge     = TRIAL_W'(rem_p) >= trial;
		assign rem_n  = ge ? RAD_W'(TRIAL_W'(rem_p) - trial) : rem_p;
		assign root_n = ge ? (root_p | (ROOT_W'(1) << BIT)) : root_p;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_n;
				root_s[k] <= root_n;
				pay_s[k]  <= pay_p;
			end
		end
	end

	assign out_valid = v_s[ROOT_W-1];
	assign out_root  = root_s[ROOT_W-1];
	assign out_pay   = pay_s[ROOT_W-1];
endmodule

// ===== rtl/euc_back.sv =====
// Back end: squares, radicand, square root, final select and result queue.
`include "eikonal_upwind_cost_update_unit_macros.svh"
module euc_back
	import euc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     mq_empty,
	output logic     mq_rd,
	input  mq_item_t mq_data,
	input  logic     pop,
	output logic     empty,
	output result_t  res
);
	logic                back_en;
	logic                v_last;
	logic [ROOT_W-1:0]   root_last;
	back_pay_t           pay_last;

	logic                v_s1, v_s2;
	logic [2*COST_W-1:0] c2_s1, d2_s1;
	back_pay_t           pay_s1, pay_s2;
	logic [RAD_W-1:0]    rad_s2;

	logic [COST_W-1:0]   m_n;
	logic [SUM_W-1:0]    msum_n;
	back_pay_t           pay_n;

	logic [SUM_W:0]      tsum_n;
	logic [SUM_W-1:0]    half_n;
	logic [COST_W-1:0]   te_n, t_n;
	result_t             res_n;

	result_t             oq_q [2];
	logic                oq_wptr_q, oq_rptr_q;
	logic [1:0]          oq_cnt_q;
	logic                oq_full, oq_wr, oq_rd;

	// Stall only when a finished result has nowhere to go
	assign oq_full = (oq_cnt_q == 2'd2);
	assign back_en = !(v_last && oq_full);
	assign mq_rd   = back_en && !mq_empty;

	// Fallback cost: smaller axis plus cell cost
	always_comb begin
		m_n            = (mq_data.tx < mq_data.ty) ? mq_data.tx : mq_data.ty;
		msum_n         = SUM_W'(m_n) + SUM_W'(mq_data.c);
		pay_n.sum      = SUM_W'(mq_data.tx) + SUM_W'(mq_data.ty);
		pay_n.use_eik  = mq_data.use_eik;
		pay_n.cur      = mq_data.cur;
		pay_n.mode     = mq_data.mode;
		if (m_n == COST_INF) begin
			pay_n.fb = COST_INF;
		end else if (msum_n > SUM_W'(COST_MAXF)) begin
			pay_n.fb = COST_MAXF;
		end else begin
			pay_n.fb = msum_n[COST_W-1:0];
		end
	end

	// Stage 1: squares of cell cost and axis gap; stage 2: radicand
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (back_en) begin
			v_s1 <= mq_rd;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (back_en) begin
			c2_s1  <= (2*COST_W)'(mq_data.c) * (2*COST_W)'(mq_data.c);
			d2_s1  <= (2*COST_W)'(mq_data.d) * (2*COST_W)'(mq_data.d);
			pay_s1 <= pay_n;
			rad_s2 <= (RAD_W'(c2_s1) << 1) - RAD_W'(d2_s1);
			pay_s2 <= pay_s1;
		end
	end

	euc_sqrt_pipe u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (back_en),
		.in_valid  (v_s2),
		.in_rad    (rad_s2),
		.in_pay    (pay_s2),
		.out_valid (v_last),
		.out_root  (root_last),
		.out_pay   (pay_last)
	);

	// Pick eikonal or fallback cost and compare against current cost
	always_comb begin
		tsum_n = (SUM_W+1)'(pay_last.sum) + (SUM_W+1)'(root_last);
		half_n = tsum_n[SUM_W:1];
		te_n   = (half_n > SUM_W'(COST_MAXF)) ? COST_MAXF : half_n[COST_W-1:0];
		t_n    = pay_last.use_eik ? te_n : pay_last.fb;
		res_n.improved        = t_n < pay_last.cur;
		res_n.new_cost        = res_n.improved ? t_n : pay_last.cur;
		res_n.joins_band      = res_n.improved && (pay_last.cur == COST_INF);
		res_n.locomotion_mode = res_n.improved ? pay_last.mode : 2'd0;
		res_n.still_infinite  = res_n.new_cost == COST_INF;
	end

	// Result queue of two entries
	assign oq_wr = v_last && back_en;
	assign oq_rd = pop && !empty;
	assign empty = (oq_cnt_q == 2'd0);
	assign res   = oq_q[oq_rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wptr_q <= 1'b0;
			oq_rptr_q <= 1'b0;
			oq_cnt_q  <= 2'd0;
		end else begin
			if (oq_wr) begin
				oq_wptr_q <= !oq_wptr_q;
			end
			if (oq_rd) begin
				oq_rptr_q <= !oq_rptr_q;
			end
			case ({oq_wr, oq_rd})
				2'b10:   oq_cnt_q <= oq_cnt_q + 1'b1;
				2'b01:   oq_cnt_q <= oq_cnt_q - 1'b1;
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (oq_wr) begin
			oq_q[oq_wptr_q] <= res_n;
		end
	end

	`EUC_ASSERT(a_oq_no_overflow, clk, arst_n, oq_wr |-> !oq_full)
	`EUC_ASSERT(a_mq_rd_nonempty, clk, arst_n, mq_rd |-> !mq_empty)
	`EUC_ASSERT_NEVER(a_oq_cnt_range, clk, arst_n, oq_cnt_q == 2'd3)
endmodule

// ===== rtl/eikonal_upwind_cost_update_unit.sv =====
// Top level of the eikonal upwind cost update unit.
//
//  channel  handshake            accept condition        payload
//  input    push / full          push && !full           neighbor costs, flags, terrain, risk
//  result   pop / empty          pop && !empty           new cost, flags, locomotion mode
//  config   cfg_valid/cfg_ready  cfg_valid && cfg_ready  cfg_index, cfg_data (ready always high)
//
// One item enters per cycle while full is low; an item passes 2 front stages, the mid queue, 2 back stages,
// 33 square root stages and the result queue.
// The one-bit-per-stage square root pipeline takes one item a cycle while the back end is not stalled.
// Reset clears all control state and loads the configuration reset values.
// A stalled result consumer freezes the back end; the mid queue then fills and full rises.
module eikonal_upwind_cost_update_unit
	import euc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	output logic                  full,
	input  logic [COST_W-1:0]     x_low_cost,
	input  logic                  x_low_present,
	input  logic [COST_W-1:0]     x_high_cost,
	input  logic                  x_high_present,
	input  logic [COST_W-1:0]     y_low_cost,
	input  logic                  y_low_present,
	input  logic [COST_W-1:0]     y_high_cost,
	input  logic                  y_high_present,
	input  logic [1:0]            terrain_class,
	input  logic [RISKF_W-1:0]    obstacle_risk,
	input  logic [COST_W-1:0]     current_cost,
	input  logic                  pop,
	output logic                  empty,
	output logic [COST_W-1:0]     new_cost,
	output logic                  improved,
	output logic                  joins_band,
	output logic [1:0]            locomotion_mode,
	output logic                  still_infinite
);
	logic     mq_wr, mq_rd, mq_full, mq_empty;
	mq_item_t mq_wdata, mq_rdata;
	result_t  res;

	euc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.x_low_cost     (x_low_cost),
		.x_low_present  (x_low_present),
		.x_high_cost    (x_high_cost),
		.x_high_present (x_high_present),
		.y_low_cost     (y_low_cost),
		.y_low_present  (y_low_present),
		.y_high_cost    (y_high_cost),
		.y_high_present (y_high_present),
		.terrain_class  (terrain_class),
		.obstacle_risk  (obstacle_risk),
		.current_cost   (current_cost),
		.mq_full        (mq_full),
		.mq_wr          (mq_wr),
		.mq_data        (mq_wdata)
	);

	euc_mid_queue u_mq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (mq_wr),
		.wdata  (mq_wdata),
		.rd     (mq_rd),
		.rdata  (mq_rdata),
		.full   (mq_full),
		.empty  (mq_empty)
	);

	euc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mq_empty (mq_empty),
		.mq_rd    (mq_rd),
		.mq_data  (mq_rdata),
		.pop      (pop),
		.empty    (empty),
		.res      (res)
	);

	// Unpack the oldest result onto the ports
	assign new_cost        = res.new_cost;
	assign improved        = res.improved;
	assign joins_band      = res.joins_band;
	assign locomotion_mode = res.locomotion_mode;
	assign still_infinite  = res.still_infinite;
endmodule
